// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared forms for concurrent checks, clocked on i_clk and masked in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define CHOL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition that implies a property in the next cycle
`define CHOL_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/chol_pkg.sv -----
// ----------------------------------------------------------------------------
// chol_pkg
// shared types, widths and helpers of the cholesky factorization block
// ----------------------------------------------------------------------------
package chol_pkg;

    localparam int WORD_W        = 48;
    localparam int ELEM_W        = 32;
    localparam int IDX_W         = 3;
    localparam int SIZE_W        = 4;
    localparam int MAX_SIZE_DEF  = 8;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [WORD_W-1:0]        t_mag;

    localparam t_mag MAG_CAP = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_LOAD,
        S_SEEK,
        S_SQRT,
        S_SQW,
        S_DIV,
        S_DVW,
        S_MUL,
        S_MLW,
        S_OSEEK,
        S_OUT
    } t_state;

    function automatic t_mag mag_of(input t_word v);
        t_mag m;
        if (v[WORD_W-1]) begin
            m = ~t_mag'(v) + 1'b1;
        end else begin
            m = t_mag'(v);
        end
        return m;
    endfunction

    // magnitude must not exceed MAG_CAP
    function automatic t_word apply_sign(input t_mag mag, input logic neg);
        t_word v;
        if (neg) begin
            v = t_word'(~mag + 1'b1);
        end else if (mag[WORD_W-1]) begin
            v = {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            v = t_word'(mag);
        end
        return v;
    endfunction

endpackage

// ----- rtl/chol_if.sv -----
// ----------------------------------------------------------------------------
// chol_if
// valid/ready channels for matrix words in and factor words out
// ----------------------------------------------------------------------------
interface chol_in_if import chol_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface chol_out_if import chol_pkg::*; ();
    logic             valid;
    logic             ready;
    t_word            factor_value;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic             last_of_run;
    logic             pivot_error;

    modport source (output valid, output factor_value, output row_index, output col_index,
                    output last_of_run, output pivot_error, input ready);
    modport sink   (input valid, input factor_value, input row_index, input col_index,
                    input last_of_run, input pivot_error, output ready);
endinterface

// ----- rtl/chol_cell.sv -----
// ----------------------------------------------------------------------------
// chol_cell
// one matrix row of the rotating row ring, with a column write port
// ----------------------------------------------------------------------------
module chol_cell import chol_pkg::*; #(
    parameter int MAX_SIZE = MAX_SIZE_DEF,
    localparam int IW = $clog2(MAX_SIZE)
) (
    input  logic                     i_clk,
    input  logic                     i_shift,
    input  t_word [MAX_SIZE-1:0]     i_row,
    input  logic                     i_we,
    input  logic [IW-1:0]            i_col,
    input  t_word                    i_data,
    output t_word [MAX_SIZE-1:0]     o_row
);

    t_word [MAX_SIZE-1:0] r_row;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_row[i_col] <= i_data;
        end else if (i_shift) begin
            r_row <= i_row;
        end
    end

    assign o_row = r_row;

endmodule

// ----- rtl/chol_sqrt.sv -----
// ----------------------------------------------------------------------------
// chol_sqrt
// bit-serial integer square root of a pivot scaled by 2^FRAC_BITS
// ----------------------------------------------------------------------------
module chol_sqrt import chol_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int RAD_W  = ((WORD_W + FRAC_BITS + 1) / 2) * 2,
    localparam int ROOT_W = RAD_W / 2,
    localparam int CNT_W  = $clog2(ROOT_W + 1)
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_value,
    output logic  o_done,
    output t_word o_root
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W:0]   r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [ROOT_W+2:0] w_cur;
    logic [ROOT_W+2:0] w_trial;
    logic              w_ge;

    assign w_cur   = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial = (ROOT_W + 3)'({r_root, 2'b01});
    assign w_ge    = (w_cur >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= RAD_W'({i_value, {FRAC_BITS{1'b0}}});
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? (ROOT_W + 1)'(w_cur - w_trial) : w_cur[ROOT_W:0];
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = t_word'(WORD_W'(r_root));

endmodule

// ----- rtl/chol_div.sv -----
// ----------------------------------------------------------------------------
// chol_div
// restoring divider, one quotient bit per cycle, fixed point and saturated
// ----------------------------------------------------------------------------
module chol_div import chol_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int NUM_W = WORD_W + FRAC_BITS,
    localparam int CNT_W = $clog2(NUM_W + 1)
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_num,
    input  t_word i_den,
    output logic  o_done,
    output t_word o_quot
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [WORD_W:0]  r_rem;
    t_mag             r_q;
    t_mag             r_den;
    logic             r_neg;
    logic             r_zero;

    logic [WORD_W+1:0] w_cur;
    logic [WORD_W+1:0] w_den_ext;
    logic              w_ge;
    logic [WORD_W:0]   w_qs;

    assign w_cur     = {r_rem, r_num[NUM_W-1]};
    assign w_den_ext = {2'b00, r_den};
    assign w_ge      = (w_cur >= w_den_ext);
    assign w_qs      = {r_q, w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(NUM_W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= {mag_of(i_num), {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_q    <= '0;
            r_den  <= t_mag'(i_den);
            r_neg  <= i_num[WORD_W-1];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= w_ge ? (WORD_W + 1)'(w_cur - w_den_ext) : w_cur[WORD_W:0];
            r_q   <= (w_qs > {1'b0, MAG_CAP}) ? MAG_CAP : w_qs[WORD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : apply_sign(r_q, r_neg);

endmodule

// ----- rtl/chol_mul.sv -----
// ----------------------------------------------------------------------------
// chol_mul
// fixed point product from four half-width partial products, summed one after another
// ----------------------------------------------------------------------------
module chol_mul import chol_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int HALF_W = WORD_W / 2,
    localparam int PROD_W = 2 * WORD_W
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_a,
    input  t_word i_b,
    output logic  o_done,
    output t_word o_prod
);

    logic              r_busy;
    logic              r_done;
    logic [1:0]        r_step;
    t_mag              r_ma;
    t_mag              r_mb;
    logic              r_neg;
    logic [PROD_W-1:0] r_acc;

    logic [HALF_W-1:0] w_ah;
    logic [HALF_W-1:0] w_bh;
    logic [WORD_W-1:0] w_pp;
    logic [PROD_W-1:0] w_add;
    logic [PROD_W-1:0] w_shr;
    t_mag              w_mag;

    always_comb begin
        w_ah = r_step[0] ? r_ma[WORD_W-1:HALF_W] : r_ma[HALF_W-1:0];
        w_bh = r_step[1] ? r_mb[WORD_W-1:HALF_W] : r_mb[HALF_W-1:0];
        w_pp = w_ah * w_bh;
        case (r_step)
            2'd0:    w_add = PROD_W'(w_pp);
            2'd3:    w_add = {w_pp, {WORD_W{1'b0}}};
            default: w_add = {{HALF_W{1'b0}}, w_pp, {HALF_W{1'b0}}};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= mag_of(i_a);
            r_mb  <= mag_of(i_b);
            r_neg <= i_a[WORD_W-1] ^ i_b[WORD_W-1];
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_add;
        end
    end

    assign w_shr  = r_acc >> FRAC_BITS;
    assign w_mag  = (w_shr > PROD_W'(MAG_CAP)) ? MAG_CAP : w_shr[WORD_W-1:0];
    assign o_done = r_done;
    assign o_prod = apply_sign(w_mag, r_neg);

endmodule

// ----- rtl/cholesky_decomposition.sv -----
// ----------------------------------------------------------------------------
// cholesky_decomposition: in-place fixed point factorization over a row ring
// load: one word per cycle, n*n words; output: n*n words, one per cycle
// within a row while the sink is ready, with a ring seek between rows
// factor: the bit-serial divider runs once per entry below the diagonal, and
// the ring seek brings each row of the ring to the head before it is worked
// reset: synchronous active low, size 8, no matrix loaded, no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cholesky_decomposition import chol_pkg::*; #(
    parameter int MAX_SIZE  = MAX_SIZE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data,
    chol_in_if.sink           i_in,
    chol_out_if.source        o_out
);

    localparam int IW = $clog2(MAX_SIZE);
    localparam int NW = $clog2(MAX_SIZE + 1);
    localparam int LW = WORD_W + ELEM_W;

    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [IW-1:0]     r_lrow, n_lrow;
    logic [IW-1:0]     r_lcol, n_lcol;
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_k, n_k;
    logic [IW-1:0]     r_i, n_i;
    logic [IW-1:0]     r_j, n_j;
    logic              r_bad, n_bad;
    t_word             r_piv, n_piv;
    t_word [MAX_SIZE-1:0] r_colv;

    logic              r_ovalid;
    t_word             r_oval;
    logic [IDX_W-1:0]  r_orow;
    logic [IDX_W-1:0]  r_ocol;
    logic              r_olast;
    logic              r_obad;

    t_word [MAX_SIZE-1:0] w_rows [MAX_SIZE];
    logic [MAX_SIZE-1:0]  w_cell_we;
    logic [NW-1:0]        w_n;
    logic [IW-1:0]        w_last;
    logic [IW-1:0]        w_head_inc;
    logic [IW:0]          w_diff;
    logic [IW-1:0]        w_pos;
    logic [ELEM_W-1:0]    w_m32;
    logic [LW-1:0]        w_lext;
    t_word                w_lval;
    logic                 w_in_acc;
    logic                 w_in_ready;
    logic                 w_lwe;
    logic                 w_cwe;
    logic [IW-1:0]        w_ccol;
    t_word                w_cdata;
    logic [IW-1:0]        w_wcol;
    t_word                w_wdata;
    logic                 w_rot;
    logic                 w_colv_we;
    logic                 w_oload;
    logic                 w_sq_start, w_dv_start, w_ml_start;
    logic                 w_sq_done, w_dv_done, w_ml_done;
    t_word                w_sq_root, w_dv_quot, w_ml_prod;
    t_word                w_hk;
    t_word                w_hj;

    function automatic t_word sat_sub(input t_word a, input t_word b);
        logic signed [WORD_W:0] d;
        t_word                  v;
        d = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        if (d[WORD_W] != d[WORD_W-1]) begin
            v = d[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            v = d[WORD_W-1:0];
        end
        return v;
    endfunction

    // effective size and ring bookkeeping
    always_comb begin
        if (r_size == '0) begin
            w_n = NW'(1);
        end else if (r_size > SIZE_W'(MAX_SIZE)) begin
            w_n = NW'(MAX_SIZE);
        end else begin
            w_n = NW'(r_size);
        end
    end

    assign w_last     = IW'(w_n - 1'b1);
    assign w_head_inc = (r_head == IW'(MAX_SIZE - 1)) ? '0 : r_head + 1'b1;
    assign w_diff     = (IW + 1)'(r_lrow) + (IW + 1)'(MAX_SIZE) - (IW + 1)'(r_head);
    assign w_pos      = (w_diff >= (IW + 1)'(MAX_SIZE)) ? IW'(w_diff - (IW + 1)'(MAX_SIZE))
                                                      : IW'(w_diff);

    // input word scaled to fixed point
    assign w_m32  = i_in.element_value[ELEM_W-1] ? ~i_in.element_value + 1'b1
                                                  : i_in.element_value;
    assign w_lext = LW'({w_m32, {FRAC_BITS{1'b0}}});
    assign w_lval = apply_sign((w_lext > LW'(MAG_CAP)) ? MAG_CAP : w_lext[WORD_W-1:0],
                               i_in.element_value[ELEM_W-1]);

    assign w_hk = w_rows[0][r_k];
    assign w_hj = w_rows[0][r_j];

    assign w_in_acc = i_in.valid && w_in_ready;

    always_comb begin
        n_state    = r_state;
        n_size     = r_size;
        n_lrow     = r_lrow;
        n_lcol     = r_lcol;
        n_head     = r_head;
        n_k        = r_k;
        n_i        = r_i;
        n_j        = r_j;
        n_bad      = r_bad;
        n_piv      = r_piv;
        w_in_ready = 1'b0;
        w_lwe      = 1'b0;
        w_cwe      = 1'b0;
        w_ccol     = r_k;
        w_cdata    = '0;
        w_rot      = 1'b0;
        w_colv_we  = 1'b0;
        w_oload    = 1'b0;
        w_sq_start = 1'b0;
        w_dv_start = 1'b0;
        w_ml_start = 1'b0;

        case (r_state)
            S_LOAD: begin
                w_in_ready = 1'b1;
                if (w_in_acc) begin
                    w_lwe = (r_lcol <= r_lrow);
                    if (r_lcol == w_last) begin
                        n_lcol = '0;
                        if (r_lrow == w_last) begin
                            n_lrow  = '0;
                            n_k     = '0;
                            n_i     = '0;
                            n_bad   = 1'b0;
                            n_state = S_SEEK;
                        end else begin
                            n_lrow = r_lrow + 1'b1;
                        end
                    end else begin
                        n_lcol = r_lcol + 1'b1;
                    end
                end
            end
            S_SEEK: begin
                if (r_head == r_i) begin
                    n_state = (r_i == r_k) ? S_SQRT : S_DIV;
                end else begin
                    w_rot  = 1'b1;
                    n_head = w_head_inc;
                end
            end
            S_SQRT: begin
                if (w_hk[WORD_W-1] || (w_hk == '0)) begin
                    n_bad = 1'b1;
                    n_piv = '0;
                    w_cwe = 1'b1;
                end else begin
                    w_sq_start = 1'b1;
                    n_state    = S_SQW;
                end
            end
            S_SQW: begin
                if (w_sq_done) begin
                    w_cwe   = 1'b1;
                    w_cdata = w_sq_root;
                    n_piv   = w_sq_root;
                end
            end
            S_DIV: begin
                w_dv_start = 1'b1;
                n_state    = S_DVW;
            end
            S_DVW: begin
                if (w_dv_done) begin
                    w_cwe     = 1'b1;
                    w_cdata   = w_dv_quot;
                    w_colv_we = 1'b1;
                    n_j       = r_k + 1'b1;
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                w_ml_start = 1'b1;
                n_state    = S_MLW;
            end
            S_MLW: begin
                if (w_ml_done) begin
                    w_cwe   = 1'b1;
                    w_ccol  = r_j;
                    w_cdata = sat_sub(w_hj, w_ml_prod);
                    if (r_j != r_i) begin
                        n_j     = r_j + 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            S_OSEEK: begin
                if (r_head == r_i) begin
                    n_state = S_OUT;
                end else begin
                    w_rot  = 1'b1;
                    n_head = w_head_inc;
                end
            end
            S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    w_oload = 1'b1;
                    if (r_j == w_last) begin
                        n_j = '0;
                        if (r_i == w_last) begin
                            n_bad   = 1'b0;
                            n_state = S_LOAD;
                        end else begin
                            n_i     = r_i + 1'b1;
                            n_state = S_OSEEK;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // row finished: next row of this column, next column, or output
        if ((r_state == S_SQRT && w_cwe) || (r_state == S_SQW && w_sq_done) ||
            (r_state == S_MLW && w_ml_done && r_j == r_i)) begin
            if (r_i == w_last) begin
                if (r_k == w_last) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = S_OSEEK;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_i     = r_k + 1'b1;
                    n_state = S_SEEK;
                end
            end else begin
                n_i     = r_i + 1'b1;
                n_state = S_SEEK;
            end
        end

        if (i_cfg_valid) begin
            n_size = i_cfg_data;
            n_lrow = '0;
            n_lcol = '0;
            n_bad  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_size   <= SIZE_RESET;
            r_lrow   <= '0;
            r_lcol   <= '0;
            r_head   <= '0;
            r_k      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_bad    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_lrow  <= n_lrow;
            r_lcol  <= n_lcol;
            r_head  <= n_head;
            r_k     <= n_k;
            r_i     <= n_i;
            r_j     <= n_j;
            r_bad   <= n_bad;
            if (w_oload) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_piv <= n_piv;
        if (w_colv_we) begin
            r_colv[r_i] <= w_dv_quot;
        end
        if (w_oload) begin
            r_oval  <= (r_j > r_i) ? '0 : w_hj;
            r_orow  <= IDX_W'(r_i);
            r_ocol  <= IDX_W'(r_j);
            r_olast <= (r_i == w_last) && (r_j == w_last);
            r_obad  <= r_bad;
        end
    end

    // row ring
    assign w_wcol  = w_lwe ? r_lcol : w_ccol;
    assign w_wdata = w_lwe ? w_lval : w_cdata;

    for (genvar c = 0; c < MAX_SIZE; c++) begin : g_cell
        assign w_cell_we[c] = (w_lwe && (w_pos == IW'(c))) || (w_cwe && (c == 0));

        chol_cell #(.MAX_SIZE(MAX_SIZE)) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_rot),
            .i_row   (w_rows[(c + 1) % MAX_SIZE]),
            .i_we    (w_cell_we[c]),
            .i_col   (w_wcol),
            .i_data  (w_wdata),
            .o_row   (w_rows[c])
        );
    end

    chol_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_value (w_hk),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    chol_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_num   (w_hk),
        .i_den   (r_piv),
        .o_done  (w_dv_done),
        .o_quot  (w_dv_quot)
    );

    chol_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ml_start),
        .i_a     (w_hk),
        .i_b     (r_colv[r_j]),
        .o_done  (w_ml_done),
        .o_prod  (w_ml_prod)
    );

    assign o_cfg_ready        = 1'b1;
    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = r_ovalid;
    assign o_out.factor_value = r_oval;
    assign o_out.row_index    = r_orow;
    assign o_out.col_index    = r_ocol;
    assign o_out.last_of_run  = r_olast;
    assign o_out.pivot_error  = r_obad;

    `CHOL_ASSERT(a_last_diag, (o_out.valid && o_out.last_of_run) |-> (o_out.row_index == o_out.col_index), "last word off the diagonal")
    `CHOL_ASSERT(a_upper_zero, (o_out.valid && (o_out.col_index > o_out.row_index)) |-> (o_out.factor_value == '0), "nonzero upper word")
    `CHOL_ASSERT(a_diag_pos, (o_out.valid && (o_out.col_index == o_out.row_index)) |-> !o_out.factor_value[WORD_W-1], "negative diagonal word")
    `CHOL_ASSERT_NEXT(a_load_done, w_in_acc && (r_lrow == w_last) && (r_lcol == w_last) && !i_cfg_valid, r_state == S_SEEK, "factor not started after last word")

endmodule
